/* rtl/plgen_pkg.sv */
// shared types and widths for the plasma pixel generator
package plgen_pkg;

  localparam int unsigned DIV_NW  = 64;                 // dividend and quotient width
  localparam int unsigned DIV_DW  = 35;                 // divisor and remainder width
  localparam int unsigned DIV_CW  = 6;                  // step count width
  localparam int unsigned DIV_SHW = $clog2(DIV_NW) + 1; // dividend alignment shift width

  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] steps;
  } div_req_t;

endpackage

/* rtl/plgen_div.sv */
// radix-2 restoring divider, one quotient bit per cycle through a shift register
module plgen_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  plgen_pkg::div_req_t          req_i,
  input  logic [plgen_pkg::DIV_NW-1:0] dividend_i,
  input  logic [plgen_pkg::DIV_DW-1:0] divisor_i,
  output logic                         busy_o,
  output logic [plgen_pkg::DIV_NW-1:0] quot_o,
  output logic [plgen_pkg::DIV_DW-1:0] rem_o
);
  import plgen_pkg::*;

  logic [DIV_NW-1:0]  q_q, q_d;
  logic [DIV_DW-1:0]  r_q, r_d, dv_q;
  logic [DIV_CW-1:0]  cnt_q;
  logic               busy_q;
  logic [DIV_DW:0]    trial, diff;
  logic [DIV_SHW-1:0] shamt;

  always_comb begin
    trial = {r_q, q_q[DIV_NW-1]};
    diff  = trial - {1'b0, dv_q};
    if (trial >= {1'b0, dv_q}) begin
      r_d = diff[DIV_DW-1:0];
      q_d = {q_q[DIV_NW-2:0], 1'b1};
    end else begin
      r_d = trial[DIV_DW-1:0];
      q_d = {q_q[DIV_NW-2:0], 1'b0};
    end
    // dividend goes to the top so the quotient ends in the low bits
    shamt = DIV_SHW'(DIV_NW) - DIV_SHW'(req_i.steps);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CW'(1);
      if (cnt_q == DIV_CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      q_q  <= dividend_i << shamt;
      r_q  <= '0;
      dv_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

/* rtl/plasma_pixel_generator_top.sv */
// plasma pixel generator: tilt-driven time counters and per-pixel sum-of-sines colour
//
// Input stream carries one item per transfer. tuser = 0 is a frame tick with a tilt
// sample, tuser = 1 asks for the colour of one pixel. Every input transfer gives
// exactly one output transfer, in order.
// A frame tick advances the two time counters and every third one latches them as
// render times; it runs two 16-step divisions.
// A lit pixel runs, per sine term, 32 CORDIC steps, then a modulo by two pi and eight
// Taylor divisions in one shared divider that retires one quotient bit per cycle.
// Pixels outside the grid or before the first latch skip straight to a black result.
// The block takes one item at a time; tready is high whenever it is not working.
// A finished result sits in the output register, and the next input is taken while
// the receiver stalls; the block only waits when a second result is ready.
// Reset clears the time counters, render times and frame phase, sets brightness to
// 255 and empties the output register. The user must make configuration writes only
// while idle; the block itself does not enforce this.
module plasma_pixel_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // tilt_x, tilt_z, pixel_x, pixel_y
  input  logic [0:0]  s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // red, green, blue, out_x, out_y, out_brightness, latched
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import plgen_pkg::*;

  localparam logic        REG_START_TIME = 1'b0;
  localparam logic        REG_BRIGHTNESS = 1'b1;
  localparam logic        MODE_FRAME     = 1'b0;
  localparam logic [1:0]  TERM_D1        = 2'd0;
  localparam logic [1:0]  TERM_D2        = 2'd1;
  localparam logic [1:0]  TERM_D3        = 2'd2;
  localparam logic [1:0]  TERM_D4        = 2'd3;
  localparam int unsigned GRID_SIZE      = 24;
  localparam logic [31:0] INV_GAIN       = 32'h9B74EDA8;
  localparam logic [34:0] TWO_PI         = 35'h6487ED511;
  localparam logic [34:0] HALF_PI        = 35'h1921FB544;
  localparam logic [31:0] ONE_Q30        = 32'h40000000;
  localparam logic signed [34:0] ACC_INIT = 35'sh100000000;
  localparam logic [DIV_CW-1:0] STEPS_TILT  = 6'd16;
  localparam logic [DIV_CW-1:0] STEPS_TY    = 6'd56;
  localparam logic [DIV_CW-1:0] STEPS_ANG   = 6'd62;
  localparam logic [DIV_CW-1:0] STEPS_TERM  = 6'd34;
  localparam logic [8:0]  TAYLOR_DIV [8] = '{9'd6, 9'd20, 9'd42, 9'd72,
                                             9'd110, 9'd156, 9'd210, 9'd272};

  typedef enum logic [4:0] {
    S_IDLE, S_TDX, S_TWX, S_TDZ, S_TWZ,
    S_PTY, S_PWTY, S_PSET, S_PCORD, S_PMHI, S_PMLO, S_PMAG,
    S_PANG, S_PWANG, S_PMOD, S_PWMOD, S_PQUAD, S_PSQ, S_PX2,
    S_PTM, S_PTD, S_PTW, S_PACC, S_RES
  } state_e;

  state_e      state_q;
  logic        mode_q, blank_q, latched_q, rendered_q, m_valid_q;
  logic [31:0] time_x_q, time_y_q, render_x_q, render_y_q;
  logic [7:0]  bright_q;
  logic [1:0]  phase_q, k_q;
  logic [4:0]  i_q;
  logic [2:0]  n_q;
  logic [47:0] m_data_q;

  logic [15:0] tx_abs_q, tz_abs_q;
  logic        tx_neg_q, tz_neg_q;
  logic [4:0]  px_q, py_q;
  logic [53:0] ty7_q;
  logic signed [59:0] cx_q, cy_q;
  logic [63:0] prod_q, ang_q;
  logic [59:0] hk_q, d_q;
  logic [34:0] r_q;
  logic [2:0]  quad_q;
  logic [30:0] sx_q, term_q;
  logic [31:0] x2_q, s_q;
  logic signed [34:0] acc_q;

  logic        in_acc;
  logic [15:0] in_tx, in_tz, in_tzn;
  logic [4:0]  in_px, in_py;
  div_req_t    div_req;
  logic [63:0] div_dvd, div_quot;
  logic [34:0] div_dvs, div_rem;
  logic        div_busy;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic signed [33:0] a_s;
  logic [32:0] a_abs;
  logic signed [9:0]  b_sm;
  logic signed [59:0] x_init, b_init, cdx, cdy;
  logic [31:0] step_x, step_z, time_y_new, tq, s_cl;
  logic [34:0] t_f;
  logic [8:0]  colour;
  logic [47:0] res_data;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign in_tx         = s_axis_tdata[15:0];
  assign in_tz         = s_axis_tdata[31:16];
  assign in_px         = s_axis_tdata[36:32];
  assign in_py         = s_axis_tdata[41:37];
  // negation wraps, so the most negative sample stays negative
  assign in_tzn        = 16'd0 - in_tz;

  plgen_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    div_req = '0;
    div_dvd = '0;
    div_dvs = '0;
    case (state_q)
      S_TDX: begin
        div_req = '{start: 1'b1, steps: STEPS_TILT};
        div_dvd = 64'(tx_abs_q);
        div_dvs = 35'd1200;
      end
      S_TDZ: begin
        div_req = '{start: 1'b1, steps: STEPS_TILT};
        div_dvd = 64'(tz_abs_q);
        div_dvs = 35'd600;
      end
      S_PTY: begin
        div_req = '{start: 1'b1, steps: STEPS_TY};
        div_dvd = {8'b0, render_y_q, 24'b0};
        div_dvs = 35'd7;
      end
      S_PANG: begin
        div_req = '{start: (k_q == TERM_D3), steps: STEPS_ANG};
        div_dvd = {d_q[55:0], 8'b0};
        div_dvs = 35'd7;
      end
      S_PMOD: begin
        div_req = '{start: 1'b1, steps: STEPS_ANG};
        div_dvd = ang_q;
        div_dvs = TWO_PI;
      end
      S_PTD: begin
        div_req = '{start: 1'b1, steps: STEPS_TERM};
        div_dvd = 64'(prod_q[62:30]);
        div_dvs = 35'(TAYLOR_DIV[n_q]);
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_PMHI: begin
        mul_a = 32'(cx_q[59:32]);
        mul_b = INV_GAIN;
      end
      S_PMLO: begin
        mul_a = cx_q[31:0];
        mul_b = INV_GAIN;
      end
      S_PSQ: begin
        mul_a = {1'b0, sx_q};
        mul_b = {1'b0, sx_q};
      end
      S_PTM: begin
        mul_a = {1'b0, term_q};
        mul_b = x2_q;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // start vector of the cordic for the current sine term
  always_comb begin
    a_s  = '0;
    b_sm = '0;
    case (k_q)
      TERM_D1: begin
        a_s  = $signed({29'b0, px_q}) + $signed({2'b0, render_x_q}) - 34'sd128;
        b_sm = $signed({5'b0, py_q}) - 10'sd128;
      end
      TERM_D2: begin
        a_s  = $signed({29'b0, px_q}) - 34'sd64;
        b_sm = $signed({5'b0, py_q}) - 10'sd64;
      end
      TERM_D3: begin
        a_s  = $signed({29'b0, px_q}) - 34'sd192;
      end
      TERM_D4: begin
        a_s  = $signed({29'b0, px_q}) - 34'sd192;
        b_sm = $signed({5'b0, py_q}) - 10'sd100;
      end
      default: ;
    endcase
    a_abs  = a_s[33] ? 33'(34'sd0 - a_s) : a_s[32:0];
    x_init = $signed({3'b0, a_abs, 24'b0});
    if (k_q == TERM_D3) begin
      b_init = $signed({31'b0, py_q, 24'b0}) + $signed({6'b0, ty7_q}) - 60'sd1073741824;
    end else begin
      b_init = $signed({{26{b_sm[9]}}, b_sm, 24'b0});
    end
  end

  assign cdx = cy_q >>> i_q;
  assign cdy = cx_q >>> i_q;

  always_comb begin
    step_x     = tx_neg_q ? 32'd0 - 32'(div_quot[5:0]) : 32'(div_quot[5:0]);
    step_z     = tz_neg_q ? 32'd0 - 32'(div_quot[5:0]) : 32'(div_quot[5:0]);
    time_y_new = time_y_q + step_z;
    tq         = 32'(div_quot[30:0]);
    t_f        = quad_q[0] ? HALF_PI - r_q : r_q;
    s_cl       = (s_q > ONE_Q30) ? ONE_Q30 : s_q;
    colour     = acc_q[33:25];
    if (mode_q == MODE_FRAME) begin
      res_data = {5'b0, latched_q, 42'b0};
    end else if (blank_q) begin
      res_data = {6'b0, bright_q, py_q, px_q, 24'b0};
    end else begin
      res_data = {6'b0, bright_q, py_q, px_q, 8'd64 - colour[7:0],
                  colour[6:0], 1'b0, colour[7:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= MODE_FRAME;
      blank_q    <= 1'b0;
      latched_q  <= 1'b0;
      rendered_q <= 1'b0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      time_x_q   <= '0;
      time_y_q   <= '0;
      render_x_q <= '0;
      render_y_q <= '0;
      bright_q   <= 8'd255;
      phase_q    <= '0;
      k_q        <= '0;
      i_q        <= '0;
      n_q        <= '0;
    end else begin
      if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            mode_q    <= s_axis_tuser[0];
            latched_q <= 1'b0;
            blank_q   <= !rendered_q || ({2'b0, in_px} >= 7'(GRID_SIZE))
                         || ({2'b0, in_py} >= 7'(GRID_SIZE));
            if (s_axis_tuser[0] == MODE_FRAME) begin
              state_q <= S_TDX;
            end else if (!rendered_q || ({2'b0, in_px} >= 7'(GRID_SIZE))
                         || ({2'b0, in_py} >= 7'(GRID_SIZE))) begin
              state_q <= S_RES;
            end else begin
              state_q <= S_PTY;
            end
          end
        end
        S_TDX:   state_q <= S_TWX;
        S_TWX: begin
          if (!div_busy) begin
            time_x_q <= time_x_q + step_x;
            state_q  <= S_TDZ;
          end
        end
        S_TDZ:   state_q <= S_TWZ;
        S_TWZ: begin
          if (!div_busy) begin
            time_y_q <= time_y_new;
            if (phase_q == 2'd2) begin
              phase_q    <= '0;
              render_x_q <= time_x_q;
              render_y_q <= time_y_new;
              rendered_q <= 1'b1;
              latched_q  <= 1'b1;
            end else begin
              phase_q <= phase_q + 2'd1;
            end
            state_q <= S_RES;
          end
        end
        S_PTY:   state_q <= S_PWTY;
        S_PWTY: begin
          if (!div_busy) begin
            k_q     <= TERM_D1;
            state_q <= S_PSET;
          end
        end
        S_PSET: begin
          i_q     <= '0;
          state_q <= S_PCORD;
        end
        S_PCORD: begin
          i_q <= i_q + 5'd1;
          if (i_q == 5'd31) begin
            state_q <= S_PMHI;
          end
        end
        S_PMHI:  state_q <= S_PMLO;
        S_PMLO:  state_q <= S_PMAG;
        S_PMAG:  state_q <= S_PANG;
        S_PANG:  state_q <= (k_q == TERM_D3) ? S_PWANG : S_PMOD;
        S_PWANG: begin
          if (!div_busy) begin
            state_q <= S_PMOD;
          end
        end
        S_PMOD:  state_q <= S_PWMOD;
        S_PWMOD: begin
          if (!div_busy) begin
            state_q <= S_PQUAD;
          end
        end
        S_PQUAD: begin
          if (r_q < HALF_PI) begin
            state_q <= S_PSQ;
          end
        end
        S_PSQ:   state_q <= S_PX2;
        S_PX2: begin
          n_q     <= '0;
          state_q <= S_PTM;
        end
        S_PTM:   state_q <= S_PTD;
        S_PTD:   state_q <= S_PTW;
        S_PTW: begin
          if (!div_busy) begin
            n_q <= n_q + 3'd1;
            state_q <= (n_q == 3'd7) ? S_PACC : S_PTM;
          end
        end
        S_PACC: begin
          k_q <= k_q + 2'd1;
          state_q <= (k_q == TERM_D4) ? S_RES : S_PSET;
        end
        S_RES: begin
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= res_data;
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_TIME: begin
            time_x_q <= cfg_data_i;
            time_y_q <= cfg_data_i;
          end
          REG_BRIGHTNESS: bright_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          tx_neg_q <= in_tx[15];
          tx_abs_q <= in_tx[15] ? 16'd0 - in_tx : in_tx;
          tz_neg_q <= in_tzn[15];
          tz_abs_q <= in_tzn[15] ? 16'd0 - in_tzn : in_tzn;
          px_q     <= in_px;
          py_q     <= in_py;
          acc_q    <= ACC_INIT;
        end
      end
      S_PWTY: begin
        if (!div_busy) begin
          ty7_q <= div_quot[53:0];
        end
      end
      S_PSET: begin
        cx_q <= x_init;
        cy_q <= b_init;
      end
      S_PCORD: begin
        if (!cy_q[59]) begin
          cx_q <= cx_q + cdx;
          cy_q <= cy_q - cdy;
        end else begin
          cx_q <= cx_q - cdx;
          cy_q <= cy_q + cdy;
        end
      end
      S_PMHI:  prod_q <= mul_p;
      S_PMLO: begin
        hk_q   <= prod_q[59:0];
        prod_q <= mul_p;
      end
      S_PMAG:  d_q <= hk_q + 60'(prod_q[63:32]);
      S_PANG: begin
        if (k_q != TERM_D3) begin
          ang_q <= {d_q[58:0], 5'b0};
        end
      end
      S_PWANG: begin
        if (!div_busy) begin
          ang_q <= div_quot;
        end
      end
      S_PWMOD: begin
        if (!div_busy) begin
          r_q    <= div_rem;
          quad_q <= '0;
        end
      end
      S_PQUAD: begin
        if (r_q >= HALF_PI) begin
          r_q    <= r_q - HALF_PI;
          quad_q <= quad_q + 3'd1;
        end else begin
          sx_q <= t_f[32:2];
        end
      end
      S_PSQ:   prod_q <= mul_p;
      S_PX2: begin
        x2_q   <= prod_q[61:30];
        term_q <= sx_q;
        s_q    <= {1'b0, sx_q};
      end
      S_PTM:   prod_q <= mul_p;
      S_PTW: begin
        if (!div_busy) begin
          term_q <= div_quot[30:0];
          // the x^3, x^7, x^11 and x^15 terms subtract and stop at zero, the others add
          if (!n_q[0]) begin
            s_q <= (s_q >= tq) ? s_q - tq : 32'd0;
          end else begin
            s_q <= s_q + tq;
          end
        end
      end
      S_PACC: begin
        if (quad_q[1]) begin
          acc_q <= acc_q - $signed({3'b0, s_cl});
        end else begin
          acc_q <= acc_q + $signed({3'b0, s_cl});
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* test/testbench.sv */
// testbench for the plasma pixel generator: frame ticks, pixel colours and register writes
`timescale 1ns / 1ps

module testbench;

  localparam longint unsigned INV_GAIN = 64'h9B74EDA8;
  localparam longint unsigned TWO_PI   = 64'h6487ED511;
  localparam longint unsigned HALF_PI  = 64'h1921FB544;
  localparam longint unsigned ONE_Q30  = 64'h40000000;
  localparam longint          Q24      = 64'sd16777216;
  localparam int              GRID     = 24;
  localparam bit              MODE_TICK  = 1'b0;
  localparam bit              MODE_PIXEL = 1'b1;
  localparam bit              REG_START  = 1'b0;
  localparam bit              REG_BRIGHT = 1'b1;

  // highest field first, so red lands in the low bits of tdata
  typedef struct packed {
    bit       latched;
    bit [7:0] bright;
    bit [4:0] py;
    bit [4:0] px;
    bit [7:0] blue;
    bit [7:0] green;
    bit [7:0] red;
  } pixel_out_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_data_i;

  plasma_pixel_generator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor copy of the block state
  bit [31:0] start_time_q;
  bit [7:0]  brightness_q;
  bit [31:0] time_x_q;
  bit [31:0] time_y_q;
  bit [1:0]  phase_q;
  bit [31:0] render_x_q;
  bit [31:0] render_y_q;
  bit        lit_q;

  pixel_out_t colour_queue[$];
  int errors;
  int ticks_sent;
  int pixels_sent;
  int latches_seen;
  int sender_idle_pct;
  int receiver_stall_pct;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint unsigned vector_length(longint a, longint b);
    longint x;
    longint y;
    longint dx;
    longint dy;
    longint unsigned ux;
    x = (a < 0) ? -a : a;
    y = b;
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
      end else begin
        x = x - dx;
        y = y + dy;
      end
    end
    ux = x;
    return (ux >> 32) * INV_GAIN + (((ux & 64'hFFFFFFFF) * INV_GAIN) >> 32);
  endfunction

  function automatic longint taylor_sine(longint unsigned ang);
    longint unsigned r;
    longint unsigned q;
    longint unsigned t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned s;
    r = ang % TWO_PI;
    q = r / HALF_PI;
    t = r - q * HALF_PI;
    q = q & 3;
    if (q[0]) t = HALF_PI - t;
    x = t >> 2;
    x2 = (x * x) >> 30;
    term = x;
    s = x;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / longint'(2 * n * (2 * n + 1));
      if (n % 2 == 1) s = (s >= term) ? s - term : 0;
      else s = s + term;
    end
    if (s > ONE_Q30) s = ONE_Q30;
    return q[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic pixel_out_t plasma_colour(bit [4:0] pxi, bit [4:0] pyi);
    pixel_out_t o;
    longint px;
    longint py;
    longint rx;
    longint ty7;
    longint unsigned d1;
    longint unsigned d2;
    longint unsigned d3;
    longint unsigned d4;
    longint sum;
    longint unsigned c;
    o = '0;
    o.px = pxi;
    o.py = pyi;
    o.bright = brightness_q;
    px = pxi;
    py = pyi;
    if (lit_q && px < GRID && py < GRID) begin
      rx = {32'b0, render_x_q};
      ty7 = (64'({32'b0, render_y_q}) * 64'd16777216) / 64'd7;
      d1 = vector_length((px + rx - 128) * Q24, (py - 128) * Q24);
      d2 = vector_length((px - 64) * Q24, (py - 64) * Q24);
      d3 = vector_length((px - 192) * Q24, py * Q24 + ty7 - 64 * Q24);
      d4 = vector_length((px - 192) * Q24, (py - 100) * Q24);
      sum = taylor_sine(d1 << 5) + taylor_sine(d2 << 5)
          + taylor_sine((d3 << 8) / 64'd7) + taylor_sine(d4 << 5);
      c = longint'(4 * ONE_Q30) + sum;
      c = c >> 25;
      o.red = c[7:0];
      o.green = 8'(c << 1);
      o.blue = 8'(64 - c);
    end
    return o;
  endfunction

  function automatic pixel_out_t advance_frame(bit [15:0] tx16, bit [15:0] tz16);
    pixel_out_t o;
    int tx;
    int tz;
    o = '0;
    tx = $signed(tx16);
    tz = -int'($signed(tz16));
    if (tz == 32768) tz = -32768;
    time_x_q = time_x_q + 32'(tx / 1200);
    time_y_q = time_y_q + 32'(tz / 600);
    phase_q = phase_q + 1;
    if (phase_q >= 3) begin
      phase_q = 0;
      render_x_q = time_x_q;
      render_y_q = time_y_q;
      lit_q = 1'b1;
      o.latched = 1'b1;
    end
    return o;
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    pixel_out_t got;
    pixel_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pixel_out_t'(m_axis_tdata[42:0]);
      if (colour_queue.size() == 0) begin
        $error("result transfer with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = colour_queue.pop_front();
        if (got.red != want.red) begin
          $error("red: expected %0d, got %0d", want.red, got.red); errors++;
        end
        if (got.green != want.green) begin
          $error("green: expected %0d, got %0d", want.green, got.green); errors++;
        end
        if (got.blue != want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, got.blue); errors++;
        end
        if (got.px != want.px) begin
          $error("out_x: expected %0d, got %0d", want.px, got.px); errors++;
        end
        if (got.py != want.py) begin
          $error("out_y: expected %0d, got %0d", want.py, got.py); errors++;
        end
        if (got.bright != want.bright) begin
          $error("out_brightness: expected %0d, got %0d", want.bright, got.bright); errors++;
        end
        if (got.latched != want.latched) begin
          $error("latched: expected %0d, got %0d", want.latched, got.latched); errors++;
        end
        if (want.latched) latches_seen++;
      end
    end
  end

  task automatic send_item(bit mode, bit [15:0] tx, bit [15:0] tz, bit [4:0] px, bit [4:0] py);
    @(negedge clk_i);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tuser = mode;
    s_axis_tdata = {6'b0, py, px, tz, tx};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (mode == MODE_TICK) begin
      colour_queue.push_back(advance_frame(tx, tz));
      ticks_sent++;
    end else begin
      colour_queue.push_back(plasma_colour(px, py));
      pixels_sent++;
    end
  endtask

  task automatic drain_results();
    while (colour_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(bit idx, bit [31:0] value);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    drain_results();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_START) begin
      start_time_q = value;
      time_x_q = value;
      time_y_q = value;
    end else begin
      brightness_q = value[7:0];
    end
  endtask

  task automatic random_pixel();
    bit [4:0] px;
    bit [4:0] py;
    px = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(GRID - 1));
    py = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(GRID - 1));
    send_item(MODE_PIXEL, 16'($urandom), 16'($urandom), px, py);
  endtask

  task automatic random_tick();
    bit [15:0] tx;
    bit [15:0] tz;
    tx = 16'($urandom);
    tz = 16'($urandom);
    case ($urandom_range(7))
      0: tx = 16'h8000;
      1: tz = 16'h8000;
      2: tx = 16'h7FFF;
      default: ;
    endcase
    send_item(MODE_TICK, tx, tz, 5'($urandom), 5'($urandom));
  endtask

  // black pixels, inside and outside the grid, and frame ticks before the first latch, with reset brightness
  task automatic test_before_latch();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_item(MODE_PIXEL, 16'h0000, 16'hFFFF, 5'd0, 5'd0);
    send_item(MODE_PIXEL, 16'hFFFF, 16'h0000, 5'd23, 5'd23);
    send_item(MODE_PIXEL, 16'h1234, 16'h5678, 5'd31, 5'd31);
    send_item(MODE_TICK, 16'h7FFF, 16'h8000, 5'd31, 5'd0);
    send_item(MODE_TICK, 16'h8000, 16'h7FFF, 5'd0, 5'd31);
    send_item(MODE_PIXEL, 16'h0000, 16'h0000, 5'd12, 5'd7);
  endtask

  // tilt extremes, latching, grid edges and register extremes
  task automatic test_directed();
    write_reg(REG_START, 32'hFFFF_FFFF);
    write_reg(REG_BRIGHT, 32'h0000_0000);
    send_item(MODE_TICK, 16'd1199, -16'sd599, 5'd0, 5'd0);
    send_item(MODE_TICK, 16'd1200, 16'd600, 5'd0, 5'd0);
    send_item(MODE_TICK, -16'sd1200, 16'h8000, 5'd0, 5'd0);
    send_item(MODE_PIXEL, 16'd0, 16'd0, 5'd0, 5'd0);
    send_item(MODE_PIXEL, 16'd0, 16'd0, 5'd23, 5'd0);
    send_item(MODE_PIXEL, 16'd0, 16'd0, 5'd0, 5'd23);
    send_item(MODE_PIXEL, 16'd0, 16'd0, 5'd23, 5'd23);
    send_item(MODE_PIXEL, 16'd0, 16'd0, 5'd24, 5'd0);
    send_item(MODE_PIXEL, 16'd0, 16'd0, 5'd0, 5'd24);
    write_reg(REG_BRIGHT, 32'hFFFF_FFAA);
    write_reg(REG_START, 32'h0000_0000);
    send_item(MODE_TICK, 16'h7FFF, 16'h8000, 5'd0, 5'd0);
    send_item(MODE_TICK, 16'h8000, 16'h7FFF, 5'd0, 5'd0);
    send_item(MODE_TICK, 16'h7FFF, 16'h8000, 5'd0, 5'd0);
    send_item(MODE_PIXEL, 16'd0, 16'd0, 5'd17, 5'd9);
    send_item(MODE_PIXEL, 16'd0, 16'd0, 5'd31, 5'd31);
  endtask

  task automatic random_phase(int idle, int stall, int count, bit [31:0] st, bit [7:0] br);
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    write_reg(REG_START, st);
    write_reg(REG_BRIGHT, {24'b0, br});
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 20) random_pixel();
      else random_tick();
    end
  endtask

  // sender holds off until every result is back, then resumes
  task automatic test_hold_off();
    sender_idle_pct = 35;
    receiver_stall_pct = 35;
    for (int k = 0; k < 40; k++) begin
      if (k == 20) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        drain_results();
      end
      if (k % 4 == 3) random_pixel();
      else random_tick();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_TICK;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_START;
    cfg_data_i = '0;
    errors = 0;
    ticks_sent = 0;
    pixels_sent = 0;
    latches_seen = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    start_time_q = '0;
    brightness_q = 8'd255;
    time_x_q = '0;
    time_y_q = '0;
    phase_q = '0;
    render_x_q = '0;
    render_y_q = '0;
    lit_q = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_before_latch();
    test_directed();
    random_phase(0, 0, 420, $urandom, 8'($urandom));
    random_phase(59, 0, 420, 32'h0000_0000, 8'd0);
    random_phase(0, 59, 420, 32'hFFFF_FFFF, 8'd255);
    random_phase(35, 35, 420, $urandom, 8'($urandom));
    test_hold_off();

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (colour_queue.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d frame ticks (%0d latches) and %0d pixel requests",
             ticks_sent, latches_seen, pixels_sent);
    $display("under four idle and stall mixes with register extremes");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
